@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/hse_pkg.sv @@
// Package for the heap sort engine: widths, control types, FSM states.
// No dependencies.
`default_nettype none

package hse_pkg;

    localparam int HSE_DATA_W = 32;
    localparam int HSE_DEPTH  = 64;

    typedef logic signed [HSE_DATA_W-1:0] hse_data_t;

    // Control strobes broadcast from the sequencer to every cell.
    typedef struct packed {
        logic ins;    // insert the incoming word into the sorted row
        logic shift;  // shift the row one place toward cell 0
    } hse_ctrl_t;

    typedef enum logic [0:0] {
        HSE_LOAD  = 1'b0,
        HSE_DRAIN = 1'b1
    } hse_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/heap_sort_engine_top.sv @@
// Top level of the heap sort engine: sequencer plus a row of DEPTH cells.
// Depends on hse_pkg, hse_ctrl and hse_cell.
`default_nettype none

// Sorts sets of signed 32-bit words. Words stream in one per cycle while
// s_ready is high; each is inserted straight into a row of DEPTH cells kept in
// ascending order. Words beyond DEPTH are discarded and every output word of
// that set carries m_dropped. The word with s_is_last closes the set; the row
// then drains from cell 0, one word per cycle that m_ready allows, smallest
// first, with m_end_of_set on the largest. No input is taken while a set
// drains. The row itself is the only storage, so there is no clearing pass
// after reset.
module heap_sort_engine_top
    import hse_pkg::*;
#(
    parameter int DEPTH = HSE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire hse_data_t s_value,
    input  wire logic      s_is_last,
    output logic           m_valid,
    input  wire logic      m_ready,
    output hse_data_t      m_sorted_value,
    output logic           m_end_of_set,
    output logic           m_dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    hse_ctrl_t        ctrl;
    logic [CNT_W-1:0] count;
    hse_data_t        cell_val [DEPTH];
    logic             cell_gt  [DEPTH];
    logic             cell_occ [DEPTH];

    hse_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_end_of_set(m_end_of_set),
        .m_dropped   (m_dropped),
        .ctrl        (ctrl),
        .count       (count)
    );

    // Occupancy: the first count cells hold the set
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_occ[i] = (CNT_W'(i) < count);
        end
    end

    // Row of cells, cell 0 holds the smallest word
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        hse_data_t prev_v, next_v;
        logic      prev_g;

        if (g == 0) begin : g_first
            assign prev_v = s_value;
            assign prev_g = 1'b0;
        end else begin : g_mid
            assign prev_v = cell_val[g-1];
            assign prev_g = cell_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_v = cell_val[g];
        end else begin : g_inner
            assign next_v = cell_val[g+1];
        end

        hse_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .ins_value (s_value),
            .occ       (cell_occ[g]),
            .prev_value(prev_v),
            .prev_gt   (prev_g),
            .next_value(next_v),
            .value     (cell_val[g]),
            .gt        (cell_gt[g])
        );
    end

    assign m_sorted_value = cell_val[0];

endmodule

`default_nettype wire

@@ hw/rtl/hse_cell.sv @@
// One cell of the sorted row: holds a single value and trades with neighbors.
// Depends on hse_pkg.
`default_nettype none

module hse_cell
    import hse_pkg::*;
(
    input  wire logic      aclk,
    input  wire hse_ctrl_t ctrl,
    input  wire hse_data_t ins_value,
    input  wire logic      occ,         // this cell holds a word of the set
    input  wire hse_data_t prev_value,  // neighbor toward cell 0
    input  wire logic      prev_gt,     // new word goes at or before the neighbor
    input  wire hse_data_t next_value,  // neighbor away from cell 0
    output hse_data_t      value,
    output logic           gt
);

    hse_data_t val_reg;
    hse_data_t val_next;

    // Incoming word belongs at or before this cell; empty cells act as +inf.
    assign gt = !occ || (ins_value < val_reg);

    // Insert: take the neighbor's word if it moves up, else the new word.
    // Drain: take the word from the far neighbor.
    always_comb begin
        val_next = val_reg;
        if (ctrl.ins && gt) begin
            val_next = prev_gt ? prev_value : ins_value;
        end else if (ctrl.shift) begin
            val_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hse_ctrl.sv @@
// Sequencer: word count, overflow flag, load/drain phases and handshakes.
// Depends on hse_pkg.
`default_nettype none

module hse_ctrl
    import hse_pkg::*;
#(
    parameter  int DEPTH = HSE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_is_last,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_end_of_set,
    output logic                   m_dropped,
    output hse_ctrl_t              ctrl,
    output logic [CNT_W-1:0]       count
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    hse_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             in_acc, out_acc;

    assign in_acc  = s_valid && (state_reg == HSE_LOAD);
    assign out_acc = m_ready && (state_reg == HSE_DRAIN);

    // Next state, count and overflow flag
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            HSE_LOAD: begin
                if (in_acc) begin
                    if (count_reg < FULL) begin
                        count_next = count_reg + ONE;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_is_last) begin
                        state_next = HSE_DRAIN;
                    end
                end
            end
            HSE_DRAIN: begin
                if (out_acc) begin
                    count_next = count_reg - ONE;
                    if (count_reg == ONE) begin
                        state_next = HSE_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = HSE_LOAD;
            end
        endcase
    end

    // Handshakes and cell strobes
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        ctrl.ins     = 1'b0;
        ctrl.shift   = 1'b0;
        unique case (state_reg)
            HSE_LOAD: begin
                s_ready  = 1'b1;
                ctrl.ins = in_acc && (count_reg < FULL);
            end
            HSE_DRAIN: begin
                m_valid    = 1'b1;
                ctrl.shift = out_acc;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_end_of_set = (count_reg == ONE);
    assign m_dropped    = ovf_reg;
    assign count        = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HSE_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hse_checker.sv @@
// Port-level checker for the heap sort engine, bound to the top level.
// Depends on hse_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hse_checker
    import hse_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      s_is_last,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire hse_data_t m_sorted_value,
    input wire logic      m_end_of_set,
    input wire logic      m_dropped
);

    logic s_acc, m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Loading and draining never overlap
    `ASSERT_IMPLY(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

    // Closing word starts the drain
    `ASSERT_NEXT(a_last_starts, aclk, aresetn, s_acc && s_is_last, m_valid)

    // Final word ends the drain
    `ASSERT_NEXT(a_end_stops, aclk, aresetn, m_acc && m_end_of_set, !m_valid && s_ready)

    // Words come out in ascending order
    `ASSERT_NEXT(a_ascending, aclk, aresetn, m_acc && !m_end_of_set, m_valid && ($past(m_sorted_value) <= m_sorted_value))

    // Overflow flag is constant within a set
    `ASSERT_NEXT(a_drop_stable, aclk, aresetn, m_acc && !m_end_of_set, m_dropped == $past(m_dropped))

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_is_last     (s_is_last),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_sorted_value(m_sorted_value),
    .m_end_of_set  (m_end_of_set),
    .m_dropped     (m_dropped)
);

`default_nettype wire

@@ verif/heap_sort_engine_top_tb.sv @@
// Testbench for heap_sort_engine_top: streams sets of signed words, predicts the
// ascending output of each set and checks every result word with a scoreboard.
// Depends on hse_pkg and the heap_sort_engine_top RTL.
`timescale 1ns / 100ps

module heap_sort_engine_top_tb
    import hse_pkg::*;
();

    // One expected result word
    typedef struct {
        hse_data_t value;
        logic      end_of_set;
        logic      dropped;
    } sorted_entry_t;

    // Collects the words of the open set; on the closing word it sorts them and
    // queues the expected output of the whole set.
    class sort_scoreboard;
        hse_data_t     set_words[$];
        bit            set_overflow;
        sorted_entry_t due[$];
        int            errors;
        int            results_seen;

        function void take_word(hse_data_t v, logic last);
            hse_data_t     arr[$];
            hse_data_t     t;
            int            j;
            sorted_entry_t e;
            // store full: the word is lost, the set is marked
            if (set_words.size() < HSE_DEPTH) set_words.push_back(v);
            else set_overflow = 1'b1;
            if (!last) return;
            arr = set_words;
            // insertion sort, signed compare
            for (int i = 1; i < arr.size(); i++) begin
                t = arr[i];
                j = i - 1;
                while (j >= 0 && arr[j] > t) begin
                    arr[j+1] = arr[j];
                    j--;
                end
                arr[j+1] = t;
            end
            for (int i = 0; i < arr.size(); i++) begin
                e.value      = arr[i];
                e.end_of_set = (i == arr.size() - 1);
                e.dropped    = set_overflow;
                due.push_back(e);
            end
            set_words.delete();
            set_overflow = 1'b0;
        endfunction

        function void check_word(hse_data_t v, logic eos, logic dr);
            sorted_entry_t e;
            results_seen++;
            if (due.size() == 0) begin
                $error("unexpected result word: sorted_value %0d", v);
                errors++;
                return;
            end
            e = due.pop_front();
            if (v !== e.value) begin
                $error("sorted_value: expected %0d, got %0d", e.value, v);
                errors++;
            end
            if (eos !== e.end_of_set) begin
                $error("end_of_set: expected %0b, got %0b", e.end_of_set, eos);
                errors++;
            end
            if (dr !== e.dropped) begin
                $error("dropped: expected %0b, got %0b", e.dropped, dr);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    hse_data_t s_value   = '0;
    logic      s_is_last = 1'b0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    hse_data_t m_sorted_value;
    logic      m_end_of_set;
    logic      m_dropped;

    sort_scoreboard sb;

    heap_sort_engine_top #(.DEPTH(HSE_DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_end_of_set   (m_end_of_set),
        .m_dropped      (m_dropped)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mix of extremes, a narrow band for ties, and full-range words
    function automatic hse_data_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return hse_data_t'($signed($urandom_range(0, 8)) - 4);
            default: return hse_data_t'($urandom);
        endcase
    endfunction

    // Offer one word, optionally after a random gap; returns once accepted
    task automatic send_word(hse_data_t v, logic last, bit calm);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_value   <= v;
        s_is_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.take_word(v, last);
    endtask

    // Result side: check accepted words, random stalls, one long hold-off
    initial begin
        int hold_left;
        bit held_once;
        int rx_cycle;
        hold_left = 0;
        held_once = 1'b0;
        rx_cycle  = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (m_valid && m_ready)
                sb.check_word(m_sorted_value, m_end_of_set, m_dropped);
            if (!held_once && sb.results_seen >= 40) begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_cycle >= 1500 && rx_cycle < 3000) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        hse_data_t dir_vals[] = '{
            32'sh7FFF_FFFF,
            32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000,
            0, -1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
            5, 5, 5, 5,
            40, 30, 20, 10, 0, -10
        };
        int dir_len[] = '{1, 1, 2, 6, 4, 6};
        int pos;
        int items_sent;
        int set_no;
        int set_size;
        int r;
        bit calm;

        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sets: extremes, mixed signs, ties, reverse order
        pos = 0;
        foreach (dir_len[k]) begin
            for (int i = 0; i < dir_len[k]; i++) begin
                send_word(dir_vals[pos], i == dir_len[k] - 1, 1'b0);
                pos++;
            end
        end

        // random sets, mostly small, some full and some overflowing
        items_sent = 0;
        set_no     = 0;
        while (items_sent < 350) begin
            if (set_no == 2) set_size = HSE_DEPTH;
            else if (set_no == 5) set_size = HSE_DEPTH + 1;  // closing word is lost
            else if (set_no == 9) set_size = HSE_DEPTH + 6;
            else begin
                r = $urandom_range(0, 99);
                if (r < 70) set_size = $urandom_range(1, 12);
                else if (r < 88) set_size = $urandom_range(13, HSE_DEPTH - 1);
                else if (r < 95) set_size = HSE_DEPTH;
                else set_size = $urandom_range(HSE_DEPTH + 1, HSE_DEPTH + 8);
            end
            for (int i = 0; i < set_size; i++) begin
                calm = (items_sent >= 120 && items_sent < 220);
                send_word(pick_value(), i == set_size - 1, calm);
                items_sent++;
            end
            set_no++;
        end
        s_valid   <= 1'b0;
        s_is_last <= 1'b0;

        // drain, then a quiet tail to catch stray words
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("heap_sort_engine_top: match");
        end else begin
            $display("heap_sort_engine_top: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("heap_sort_engine_top: mismatch");
        $finish;
    end

endmodule
